// ===== sv/sqh_pkg.sv =====
// shared types and constants of the stack / queue / heap trace classifier
// no dependencies
package sqh_pkg;

	// field widths fixed by the stream format
	localparam int unsigned VALUE_W   = 16;
	localparam int unsigned VERDICT_W = 3;

	// defaults of the top level parameters
	localparam int unsigned DEF_DEPTH      = 1024;
	localparam int unsigned DEF_VALUE_BITS = 16;

	// operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// candidate bit positions
	localparam int unsigned CAND_STACK = 0;
	localparam int unsigned CAND_QUEUE = 1;
	localparam int unsigned CAND_HEAP  = 2;

	// verdict codes
	localparam logic [VERDICT_W-1:0] VERDICT_IMPOSSIBLE = 3'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_NOT_SURE   = 3'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_QUEUE      = 3'd2;
	localparam logic [VERDICT_W-1:0] VERDICT_STACK      = 3'd3;
	localparam logic [VERDICT_W-1:0] VERDICT_PRIO       = 3'd4;

	// one trace operation as it travels from front to back
	typedef struct packed {
		logic               op;
		logic [VALUE_W-1:0] value;
		logic               last;
	} item_t;

	// back end sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_STK,
		S_STK_CMP,
		S_FQ,
		S_FQ_CMP,
		S_HP,
		S_HI_RD,
		S_HI_CMP,
		S_HR_CMP0,
		S_HR_LAST,
		S_HR_L,
		S_HR_R,
		S_HR_SEL,
		S_FIN
	} state_t;

endpackage

// ===== sv/sqh_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module sqh_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/sqh_front.sv =====
// front end: accepts trace beats into a two entry queue
// depends on sqh_pkg
module sqh_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [15:0]   s_tdata,  // value
	input  logic          s_tuser,  // operation
	input  logic          s_tlast,  // last_of_case
	output logic          item_valid,
	output sqh_pkg::item_t item,
	input  logic          item_take
);

	sqh_pkg::item_t ent_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;

	assign s_tready   = (cnt_q != 2'd2);
	assign push       = s_tvalid && s_tready;
	assign item_valid = (cnt_q != 2'd0);
	assign pop        = item_valid && item_take;
	assign item       = ent_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= '{op: s_tuser, value: s_tdata, last: s_tlast};
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/sqh_back.sv =====
// back end: replays each operation on stack, queue and max heap, reports verdicts
// depends on sqh_pkg and sqh_ram
module sqh_back #(
	parameter int unsigned DEPTH      = sqh_pkg::DEF_DEPTH,
	parameter int unsigned VALUE_BITS = sqh_pkg::DEF_VALUE_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  sqh_pkg::item_t item,
	output logic           item_take,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata  // verdict[2:0], overflow, zero pad
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned LW = CW + 1;
	localparam int unsigned VW = (VALUE_BITS < sqh_pkg::VALUE_W) ? VALUE_BITS
		: sqh_pkg::VALUE_W;
	localparam logic [CW-1:0] FULL   = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

	sqh_pkg::state_t state_q, state_d;

	logic          op_q, op_d;
	logic [VW-1:0] val_q, val_d;
	logic          last_q, last_d;
	logic [CW-1:0] stk_cnt_q, stk_cnt_d;
	logic [AW-1:0] f_head_q, f_head_d;
	logic [AW-1:0] f_tail_q, f_tail_d;
	logic [CW-1:0] f_cnt_q, f_cnt_d;
	logic [CW-1:0] h_cnt_q, h_cnt_d;
	logic [2:0]    alive_q, alive_d;
	logic          ovf_q, ovf_d;
	logic [CW-1:0] hi_q, hi_d;
	logic [VW-1:0] hv_q, hv_d;
	logic [VW-1:0] lval_q, lval_d;
	logic          out_valid_q, out_valid_d;
	logic [sqh_pkg::VERDICT_W-1:0] out_verdict_q, out_verdict_d;
	logic          out_ovf_q, out_ovf_d;

	logic          s_we, f_we, h_we;
	logic [AW-1:0] s_waddr, s_raddr, f_waddr, f_raddr, h_waddr, h_raddr;
	logic [VW-1:0] h_wdata;
	logic [VW-1:0] s_rdata, f_rdata, h_rdata;

	logic [CW-1:0] parent;
	logic [LW-1:0] lidx, ridx;
	logic          r_ok;
	logic [1:0]    n_alive;
	logic [sqh_pkg::VERDICT_W-1:0] verdict;

	// stores of the three candidates
	sqh_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_stk_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(val_q),
		.raddr(s_raddr), .rdata(s_rdata)
	);
	sqh_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_fq_ram (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(val_q),
		.raddr(f_raddr), .rdata(f_rdata)
	);
	sqh_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_heap_ram (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	// heap index arithmetic
	assign parent = (hi_q - CW'(1)) >> 1;
	assign lidx   = {hi_q, 1'b1};
	assign ridx   = lidx + LW'(1);
	assign r_ok   = (ridx < LW'(h_cnt_q));

	// verdict from surviving candidates
	assign n_alive = 2'(alive_q[0]) + 2'(alive_q[1]) + 2'(alive_q[2]);
	always_comb begin
		case (n_alive)
			2'd0: verdict = sqh_pkg::VERDICT_IMPOSSIBLE;
			2'd1: begin
				if (alive_q[sqh_pkg::CAND_QUEUE]) begin
					verdict = sqh_pkg::VERDICT_QUEUE;
				end else if (alive_q[sqh_pkg::CAND_STACK]) begin
					verdict = sqh_pkg::VERDICT_STACK;
				end else begin
					verdict = sqh_pkg::VERDICT_PRIO;
				end
			end
			default: verdict = sqh_pkg::VERDICT_NOT_SURE;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_ovf_q, out_verdict_q};

	// sequencer next state and datapath control
	always_comb begin
		state_d       = state_q;
		op_d          = op_q;
		val_d         = val_q;
		last_d        = last_q;
		stk_cnt_d     = stk_cnt_q;
		f_head_d      = f_head_q;
		f_tail_d      = f_tail_q;
		f_cnt_d       = f_cnt_q;
		h_cnt_d       = h_cnt_q;
		alive_d       = alive_q;
		ovf_d         = ovf_q;
		hi_d          = hi_q;
		hv_d          = hv_q;
		lval_d        = lval_q;
		out_valid_d   = out_valid_q && !m_tready;
		out_verdict_d = out_verdict_q;
		out_ovf_d     = out_ovf_q;
		item_take     = 1'b0;
		s_we          = 1'b0;
		f_we          = 1'b0;
		h_we          = 1'b0;
		s_waddr       = stk_cnt_q[AW-1:0];
		s_raddr       = AW'(stk_cnt_q - CW'(1));
		f_waddr       = f_tail_q;
		f_raddr       = f_head_q;
		h_waddr       = hi_q[AW-1:0];
		h_wdata       = hv_q;
		h_raddr       = '0;
		case (state_q)
			sqh_pkg::S_IDLE: begin
				if (item_valid) begin
					item_take = 1'b1;
					op_d      = item.op;
					val_d     = item.value[VW-1:0];
					last_d    = item.last;
					state_d   = sqh_pkg::S_STK;
				end
			end
			// stack
			sqh_pkg::S_STK: begin
				state_d = sqh_pkg::S_FQ;
				if (alive_q[sqh_pkg::CAND_STACK]) begin
					if (op_q == sqh_pkg::OP_PUSH) begin
						if (stk_cnt_q == FULL) begin
							alive_d[sqh_pkg::CAND_STACK] = 1'b0;
							ovf_d = 1'b1;
						end else begin
							s_we      = 1'b1;
							stk_cnt_d = stk_cnt_q + CW'(1);
						end
					end else if (stk_cnt_q == '0) begin
						alive_d[sqh_pkg::CAND_STACK] = 1'b0;
					end else begin
						state_d = sqh_pkg::S_STK_CMP;
					end
				end
			end
			sqh_pkg::S_STK_CMP: begin
				state_d = sqh_pkg::S_FQ;
				if (s_rdata != val_q) begin
					alive_d[sqh_pkg::CAND_STACK] = 1'b0;
				end else begin
					stk_cnt_d = stk_cnt_q - CW'(1);
				end
			end
			// queue
			sqh_pkg::S_FQ: begin
				state_d = sqh_pkg::S_HP;
				if (alive_q[sqh_pkg::CAND_QUEUE]) begin
					if (op_q == sqh_pkg::OP_PUSH) begin
						if (f_cnt_q == FULL) begin
							alive_d[sqh_pkg::CAND_QUEUE] = 1'b0;
							ovf_d = 1'b1;
						end else begin
							f_we     = 1'b1;
							f_tail_d = (f_tail_q == LAST_A) ? '0 : f_tail_q + AW'(1);
							f_cnt_d  = f_cnt_q + CW'(1);
						end
					end else if (f_cnt_q == '0) begin
						alive_d[sqh_pkg::CAND_QUEUE] = 1'b0;
					end else begin
						state_d = sqh_pkg::S_FQ_CMP;
					end
				end
			end
			sqh_pkg::S_FQ_CMP: begin
				state_d = sqh_pkg::S_HP;
				if (f_rdata != val_q) begin
					alive_d[sqh_pkg::CAND_QUEUE] = 1'b0;
				end else begin
					f_head_d = (f_head_q == LAST_A) ? '0 : f_head_q + AW'(1);
					f_cnt_d  = f_cnt_q - CW'(1);
				end
			end
			// heap entry
			sqh_pkg::S_HP: begin
				state_d = sqh_pkg::S_FIN;
				if (alive_q[sqh_pkg::CAND_HEAP]) begin
					if (op_q == sqh_pkg::OP_PUSH) begin
						if (h_cnt_q == FULL) begin
							alive_d[sqh_pkg::CAND_HEAP] = 1'b0;
							ovf_d = 1'b1;
						end else begin
							h_cnt_d = h_cnt_q + CW'(1);
							hi_d    = h_cnt_q;
							hv_d    = val_q;
							state_d = sqh_pkg::S_HI_RD;
						end
					end else if (h_cnt_q == '0) begin
						alive_d[sqh_pkg::CAND_HEAP] = 1'b0;
					end else begin
						h_raddr = '0;
						state_d = sqh_pkg::S_HR_CMP0;
					end
				end
			end
			// heap insert: sift up one level per pass
			sqh_pkg::S_HI_RD: begin
				if (hi_q == '0) begin
					h_we    = 1'b1;
					state_d = sqh_pkg::S_FIN;
				end else begin
					h_raddr = parent[AW-1:0];
					state_d = sqh_pkg::S_HI_CMP;
				end
			end
			sqh_pkg::S_HI_CMP: begin
				h_we = 1'b1;
				if (h_rdata >= hv_q) begin
					state_d = sqh_pkg::S_FIN;
				end else begin
					h_wdata = h_rdata;
					hi_d    = parent;
					state_d = sqh_pkg::S_HI_RD;
				end
			end
			// heap remove: check top, fetch last leaf
			sqh_pkg::S_HR_CMP0: begin
				if (h_rdata != val_q) begin
					alive_d[sqh_pkg::CAND_HEAP] = 1'b0;
					state_d = sqh_pkg::S_FIN;
				end else begin
					h_cnt_d = h_cnt_q - CW'(1);
					h_raddr = AW'(h_cnt_q - CW'(1));
					state_d = (h_cnt_q == CW'(1)) ? sqh_pkg::S_FIN : sqh_pkg::S_HR_LAST;
				end
			end
			sqh_pkg::S_HR_LAST: begin
				hv_d    = h_rdata;
				hi_d    = '0;
				state_d = sqh_pkg::S_HR_L;
			end
			// heap remove: sift down, read left then right child
			sqh_pkg::S_HR_L: begin
				if (lidx >= LW'(h_cnt_q)) begin
					h_we    = 1'b1;
					state_d = sqh_pkg::S_FIN;
				end else begin
					h_raddr = lidx[AW-1:0];
					state_d = sqh_pkg::S_HR_R;
				end
			end
			sqh_pkg::S_HR_R: begin
				lval_d  = h_rdata;
				h_raddr = ridx[AW-1:0];
				state_d = sqh_pkg::S_HR_SEL;
			end
			sqh_pkg::S_HR_SEL: begin
				h_we = 1'b1;
				if (r_ok && (h_rdata > lval_q)) begin
					if (h_rdata <= hv_q) begin
						state_d = sqh_pkg::S_FIN;
					end else begin
						h_wdata = h_rdata;
						hi_d    = ridx[CW-1:0];
						state_d = sqh_pkg::S_HR_L;
					end
				end else if (lval_q <= hv_q) begin
					state_d = sqh_pkg::S_FIN;
				end else begin
					h_wdata = lval_q;
					hi_d    = lidx[CW-1:0];
					state_d = sqh_pkg::S_HR_L;
				end
			end
			// verdict beat and case clear
			sqh_pkg::S_FIN: begin
				if (!last_q) begin
					state_d = sqh_pkg::S_IDLE;
				end else if (!out_valid_q || m_tready) begin
					out_valid_d   = 1'b1;
					out_verdict_d = verdict;
					out_ovf_d     = ovf_q;
					stk_cnt_d     = '0;
					f_head_d      = '0;
					f_tail_d      = '0;
					f_cnt_d       = '0;
					h_cnt_d       = '0;
					alive_d       = '1;
					ovf_d         = 1'b0;
					state_d       = sqh_pkg::S_IDLE;
				end
			end
			default: state_d = sqh_pkg::S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sqh_pkg::S_IDLE;
			stk_cnt_q   <= '0;
			f_head_q    <= '0;
			f_tail_q    <= '0;
			f_cnt_q     <= '0;
			h_cnt_q     <= '0;
			alive_q     <= '1;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			stk_cnt_q   <= stk_cnt_d;
			f_head_q    <= f_head_d;
			f_tail_q    <= f_tail_d;
			f_cnt_q     <= f_cnt_d;
			h_cnt_q     <= h_cnt_d;
			alive_q     <= alive_d;
			ovf_q       <= ovf_d;
			out_valid_q <= out_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		op_q          <= op_d;
		val_q         <= val_d;
		last_q        <= last_d;
		hi_q          <= hi_d;
		hv_q          <= hv_d;
		lval_q        <= lval_d;
		out_verdict_q <= out_verdict_d;
		out_ovf_q     <= out_ovf_d;
	end

	// counts stay within capacity
	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(stk_cnt_q <= FULL) && (f_cnt_q <= FULL) && (h_cnt_q <= FULL))
		else $error("candidate count above capacity");

	// empty queue has coinciding pointers
	a_fifo_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(f_cnt_q == '0) |-> (f_head_q == f_tail_q))
		else $error("queue pointers differ while empty");

	// a verdict beat clears the case
	a_case_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(out_valid_q) || $past(m_tready)) && $rose(out_valid_q)
		|-> (alive_q == 3'b111) && !ovf_q && (h_cnt_q == '0))
		else $error("case state not cleared after verdict");

	// overflow implies some candidate dropped
	a_ovf_fail: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (alive_q != 3'b111))
		else $error("overflow without failed candidate");

	// a pending verdict is held while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$past(out_valid_q) && !$past(m_tready) |-> out_valid_q && $stable(m_tdata))
		else $error("verdict beat changed while stalled");

endmodule

// ===== sv/stack_queue_heap_trace_classifier.sv =====
// top level of the stack / queue / heap trace classifier
// depends on sqh_pkg, sqh_front, sqh_back (and sqh_ram below it)
//
// Usage:
//   s_* channel carries one push or pop per beat: tdata = value, tuser = operation
//   (0 push, 1 pop), tlast = last operation of a trace.
//   m_* channel carries one verdict beat per trace, after its last operation.
//   Each operation replays on a stack, a queue and a max heap held in three rams.
//   Each operation visits the stack, then the queue, then the heap; a failed
//   candidate is skipped. Heap push sifts up and heap pop sifts down, one level
//   per pass; the heap sift loop, one ram read per step through a single read
//   port, sets how long an operation takes.
//   A two entry queue in front takes new beats while the back end works.
//   Reset clears counts, pointers and flags; ram contents need no clearing.
//   While m_tready is low a verdict beat waits in its output register; the back
//   end stalls only when a second verdict is ready, and then s_tready drops once
//   the front queue fills.
module stack_queue_heap_trace_classifier #(
	parameter int unsigned DEPTH      = sqh_pkg::DEF_DEPTH,
	parameter int unsigned VALUE_BITS = sqh_pkg::DEF_VALUE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // value
	input  logic        s_tuser,  // operation
	input  logic        s_tlast,  // last_of_case
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // verdict[2:0], overflow[3], zero pad
);

	logic           item_valid;
	logic           item_take;
	sqh_pkg::item_t item;

	// beat intake
	sqh_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tlast(s_tlast),
		.item_valid(item_valid), .item(item), .item_take(item_take)
	);

	// replay and verdict
	sqh_back #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item(item), .item_take(item_take),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

endmodule
